// ===== sv/rmpv_pkg.sv =====
// ----------------------------------------------------------------------------
// rmpv_pkg
// Shared constants for the ring-modulated percussion voice: register map,
// sample-rate limits, divider sizes and sine polynomial coefficients.
// ----------------------------------------------------------------------------
package rmpv_pkg;

    localparam int DEF_PHASE_BITS = 24;
    localparam int DEF_SINE_DEPTH = 1024;
    localparam int DEF_CV_BITS    = 16;

    localparam int KNOB_W = 12;
    localparam int FS_W   = 18;
    localparam int CTRL_W = 17;
    localparam int ENV_W  = 17;
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [2:0] REG_YIP    = 3'd0;
    localparam logic [2:0] REG_YAP    = 3'd1;
    localparam logic [2:0] REG_GROWL  = 3'd2;
    localparam logic [2:0] REG_TAIL   = 3'd3;
    localparam logic [2:0] REG_SQUARE = 3'd4;
    localparam logic [2:0] REG_FS     = 3'd5;

    localparam logic [FS_W-1:0] FS_RESET = 18'd44100;
    localparam logic [FS_W-1:0] FS_MIN   = 18'd8000;
    localparam logic [FS_W-1:0] FS_MAX   = 18'd192000;

    localparam int DIV_N = 58;
    localparam int DIV_D = 42;
    localparam logic [DIV_N-1:0] E_NUM = 58'd1000 << 48;

    localparam logic [31:0] SIN_C1 = 32'd1686629713;
    localparam logic [31:0] SIN_C3 = 32'd693598669;
    localparam logic [31:0] SIN_C5 = 32'd85569306;
    localparam logic [31:0] SIN_C7 = 32'd5026994;

    localparam logic [ENV_W-1:0] ENV_ONE  = 17'd65536;
    localparam logic [ENV_W-1:0] ENV_SNAP = 17'd656;
    localparam logic [16:0]      RECIP3   = 17'd43691;

    typedef logic [CTRL_W-1:0] t_ctrl;

endpackage

// ===== sv/ring_mod_percussion_voice_core.sv =====
// ----------------------------------------------------------------------------
// ring_mod_percussion_voice_core
// Two-oscillator ring-modulated drum voice with exponential decay envelope,
// computed per sample on one shared multiplier and one restoring divider.
// ----------------------------------------------------------------------------
//  channel  | handshake                      | payload
//  in       | i_in_valid / o_in_stall        | six control voltage words
//  out      | o_out_valid / i_out_stall      | o_voice_sample, o_led_level
//  cfg      | psel penable pwrite pready     | paddr, pwdata, prdata
//
//  The sequencer runs three 58-step divisions and 21 multiplier passes
//  for each accepted word before the result is valid.
//  A new word is accepted only while the sequencer is idle.
//  A finished result waits in the output register; the next word may be
//  accepted meanwhile, and only the final step waits for that register.
//  Reset is synchronous and active low.
// ----------------------------------------------------------------------------
module ring_mod_percussion_voice_core #(
    parameter int PHASE_BITS       = rmpv_pkg::DEF_PHASE_BITS,
    parameter int SINE_TABLE_DEPTH = rmpv_pkg::DEF_SINE_DEPTH,
    parameter int CV_BITS          = rmpv_pkg::DEF_CV_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [CV_BITS-1:0]         i_yip_cv,
    input  logic signed [CV_BITS-1:0]         i_yap_cv,
    input  logic signed [CV_BITS-1:0]         i_growl_cv,
    input  logic signed [CV_BITS-1:0]         i_tail_cv,
    input  logic signed [CV_BITS-1:0]         i_bang_cv,
    input  logic signed [CV_BITS-1:0]         i_square_gate_cv,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [CV_BITS-1:0]         o_voice_sample,
    output logic [rmpv_pkg::ENV_W-1:0]        o_led_level,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rmpv_pkg::APB_AW-1:0]       paddr,
    input  logic [rmpv_pkg::APB_DW-1:0]       pwdata,
    output logic [rmpv_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);
    import rmpv_pkg::*;

    localparam int SINE_BITS = $clog2(SINE_TABLE_DEPTH);
    localparam int CVX_W     = CV_BITS + 18;
    localparam int HV_W      = CV_BITS + 6;
    localparam int YV_W      = CV_BITS + 4;
    localparam int DCNT_W    = $clog2(DIV_N + 1);
    localparam int HI_TH_I   = 1 << (CV_BITS - 1);
    localparam int LIM_I     = 1 << (CV_BITS - 2);
    localparam logic signed [HV_W-1:0]    HI_TH   = HV_W'(HI_TH_I);
    localparam logic signed [YV_W-1:0]    Y_LIM   = YV_W'(LIM_I);
    localparam logic signed [CV_BITS-1:0] OUT_LIM = CV_BITS'(LIM_I);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_CTRL    = 5'd1;
    localparam logic [4:0] S_TMUL    = 5'd2;
    localparam logic [4:0] S_EDIV_LD = 5'd3;
    localparam logic [4:0] S_EDIV    = 5'd4;
    localparam logic [4:0] S_E2      = 5'd5;
    localparam logic [4:0] S_E3      = 5'd6;
    localparam logic [4:0] S_E4      = 5'd7;
    localparam logic [4:0] S_D6      = 5'd8;
    localparam logic [4:0] S_D24     = 5'd9;
    localparam logic [4:0] S_ENV     = 5'd10;
    localparam logic [4:0] S_PH1_LD  = 5'd11;
    localparam logic [4:0] S_PH1_DIV = 5'd12;
    localparam logic [4:0] S_PH2_LD  = 5'd13;
    localparam logic [4:0] S_PH2_DIV = 5'd14;
    localparam logic [4:0] S_A_X2    = 5'd15;
    localparam logic [4:0] S_A_P7    = 5'd16;
    localparam logic [4:0] S_A_P5    = 5'd17;
    localparam logic [4:0] S_A_P3    = 5'd18;
    localparam logic [4:0] S_A_P1    = 5'd19;
    localparam logic [4:0] S_A_S     = 5'd20;
    localparam logic [4:0] S_RING    = 5'd21;
    localparam logic [4:0] S_MIXA    = 5'd22;
    localparam logic [4:0] S_MIXB    = 5'd23;
    localparam logic [4:0] S_OUT_MUL = 5'd24;
    localparam logic [4:0] S_OUT     = 5'd25;

    function automatic logic [CTRL_W-1:0] knob_q16(input logic [KNOB_W-1:0] k);
        logic [CTRL_W-1:0] k16;
        logic [17:0]       x;
        logic [17:0]       y;
        k16 = {1'b0, k, 4'b0};
        x   = {1'b0, k16} + 18'd2047;
        y   = x + {12'b0, x[17:12]} + 18'd1;
        return k16 + {11'b0, y[17:12]};
    endfunction

    function automatic t_ctrl control_q16(input logic [KNOB_W-1:0] k,
                                          input logic signed [CV_BITS-1:0] cv);
        logic signed [CVX_W-1:0] cx;
        logic signed [19:0]      cterm;
        logic signed [19:0]      sum;
        cx    = CVX_W'(cv) <<< 17;
        cterm = 20'(cx >>> CV_BITS);
        sum   = $signed({3'b0, knob_q16(k)}) + 20'sd3277 + cterm;
        if (sum < 20'sd0) begin
            return '0;
        end else if (sum > 20'sd65536) begin
            return ENV_ONE;
        end
        return sum[CTRL_W-1:0];
    endfunction

    function automatic logic is_high(input logic signed [CV_BITS-1:0] cv);
        logic signed [HV_W-1:0] v;
        logic signed [HV_W-1:0] v20;
        v   = HV_W'(cv);
        v20 = (v <<< 4) + (v <<< 2);
        return v20 > HI_TH;
    endfunction

    function automatic logic [24:0] freq_q16(input t_ctrl c);
        return 25'd1310720 + 25'(c) * 25'd280;
    endfunction

    logic [4:0]                r_state;
    logic                      r_mw;
    logic                      r_ovalid;
    logic [KNOB_W-1:0]         r_yip_knob, r_yap_knob, r_growl_knob, r_tail_knob;
    logic                      r_sq_sw;
    logic [FS_W-1:0]           r_fs;
    logic signed [CV_BITS-1:0] r_yip_cv, r_yap_cv, r_growl_cv, r_tail_cv;
    logic signed [CV_BITS-1:0] r_bang_cv, r_gate_cv;
    t_ctrl                     r_c1, r_c2, r_g, r_ct;
    logic                      r_sq;
    logic [ENV_W-1:0]          r_env;
    logic                      r_run;
    logic                      r_prev;
    logic [PHASE_BITS-1:0]     r_ph1, r_ph2;
    logic signed [35:0]        r_ma;
    logic signed [31:0]        r_mb;
    logic signed [67:0]        r_prod;
    logic [DIV_D:0]            r_rem;
    logic [DIV_N-1:0]          r_quo;
    logic [DIV_D-1:0]          r_den;
    logic [DCNT_W-1:0]         r_dcnt;
    logic [26:0]               r_e;
    logic [21:0]               r_e2;
    logic [16:0]               r_e3;
    logic [11:0]               r_e4;
    logic [13:0]               r_d6;
    logic [30:0]               r_x, r_x2;
    logic                      r_osc;
    logic signed [16:0]        r_wa, r_wb;
    logic signed [35:0]        r_ring;
    logic signed [49:0]        r_macc;
    logic signed [CV_BITS-1:0] r_out;
    logic [ENV_W-1:0]          r_led;

    logic [FS_W-1:0]           fs_sat;
    logic [DIV_D:0]            div_sh;
    logic [DIV_D+1:0]          div_diff;
    logic                      div_ge;
    logic [PHASE_BITS-1:0]     sel_ph;
    logic [SINE_BITS-1:0]      sin_k;
    logic [30:0]               x0, x_v;
    logic [32:0]               s_rnd;
    logic [16:0]               s_mag;
    logic signed [16:0]        w_v;
    logic [33:0]               alpha;
    logic signed [35:0]        pp, ring_v;
    logic signed [17:0]        wsum;
    logic signed [32:0]        dry_v;
    logic signed [49:0]        msum;
    logic signed [33:0]        mix_v;
    logic signed [67:0]        y_full;
    logic signed [YV_W-1:0]    y_v, y_c;
    logic [24:0]               t_ms;
    logic                      bang_v;
    logic                      cfg_wr;

    always_comb begin
        if (r_fs < FS_MIN) begin
            fs_sat = FS_MIN;
        end else if (r_fs > FS_MAX) begin
            fs_sat = FS_MAX;
        end else begin
            fs_sat = r_fs;
        end
    end

    assign div_sh   = {r_rem[DIV_D-1:0], r_quo[DIV_N-1]};
    assign div_diff = {1'b0, div_sh} - {2'b0, r_den};
    assign div_ge   = !div_diff[DIV_D+1];

    assign sel_ph = r_osc ? r_ph2 : r_ph1;
    assign sin_k  = sel_ph[PHASE_BITS-1 -: SINE_BITS];
    assign x0     = 31'(sin_k[SINE_BITS-3:0]) << (32 - SINE_BITS);
    assign x_v    = sin_k[SINE_BITS-2] ? (31'h4000_0000 - x0) : x0;
    assign s_rnd  = {1'b0, r_prod[61:30]} + 33'd16384;
    assign s_mag  = s_rnd[31:15];

    always_comb begin
        if (r_sq) begin
            w_v = sel_ph[PHASE_BITS-1] ? -17'sd32768 : 17'sd32768;
        end else if (sin_k[SINE_BITS-1]) begin
            w_v = -$signed(s_mag);
        end else begin
            w_v = $signed(s_mag);
        end
    end

    assign alpha  = 34'h1_0000_0000 - {7'b0, r_e} + {13'b0, r_e2[21:1]}
                  - {20'b0, r_d6} + {26'b0, r_prod[24:17]};
    assign pp     = r_prod[35:0];
    assign ring_v = ((pp <<< 4) - pp) >>> 3;
    assign wsum   = 18'(r_wa) + 18'(r_wb);
    assign dry_v  = {wsum, 15'b0};
    assign msum   = r_macc + $signed(r_prod[49:0]);
    assign mix_v  = msum[49:16];
    assign y_full = r_prod >>> (49 - CV_BITS);
    assign y_v    = y_full[YV_W-1:0];
    assign y_c    = (y_v > Y_LIM) ? Y_LIM : ((y_v < -Y_LIM) ? -Y_LIM : y_v);
    assign t_ms   = 25'd327680 + 25'(r_ct) * 25'd295;
    assign bang_v = is_high(r_bang_cv);
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mw         <= 1'b0;
            r_ovalid     <= 1'b0;
            r_yip_knob   <= '0;
            r_yap_knob   <= '0;
            r_growl_knob <= '0;
            r_tail_knob  <= '0;
            r_sq_sw      <= 1'b0;
            r_fs         <= FS_RESET;
            r_env        <= '0;
            r_run        <= 1'b0;
            r_prev       <= 1'b0;
            r_ph1        <= '0;
            r_ph2        <= '0;
            r_dcnt       <= '0;
            r_osc        <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[APB_AW-1:2])
                    REG_YIP:    r_yip_knob   <= pwdata[KNOB_W-1:0];
                    REG_YAP:    r_yap_knob   <= pwdata[KNOB_W-1:0];
                    REG_GROWL:  r_growl_knob <= pwdata[KNOB_W-1:0];
                    REG_TAIL:   r_tail_knob  <= pwdata[KNOB_W-1:0];
                    REG_SQUARE: r_sq_sw      <= pwdata[0];
                    REG_FS:     r_fs         <= pwdata[FS_W-1:0];
                    default: ;
                endcase
            end
            if (r_ovalid && !i_out_stall && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            r_prod <= r_ma * r_mb;

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_yip_cv   <= i_yip_cv;
                        r_yap_cv   <= i_yap_cv;
                        r_growl_cv <= i_growl_cv;
                        r_tail_cv  <= i_tail_cv;
                        r_bang_cv  <= i_bang_cv;
                        r_gate_cv  <= i_square_gate_cv;
                        r_state    <= S_CTRL;
                    end
                end
                S_CTRL: begin
                    r_c1 <= control_q16(r_yip_knob, r_yip_cv);
                    r_c2 <= control_q16(r_yap_knob, r_yap_cv);
                    r_g  <= control_q16(r_growl_knob, r_growl_cv);
                    r_ct <= control_q16(r_tail_knob, r_tail_cv);
                    r_sq <= r_sq_sw || is_high(r_gate_cv);
                    if (bang_v && !r_prev) begin
                        r_env <= ENV_ONE;
                        r_run <= 1'b1;
                    end
                    r_prev  <= bang_v;
                    r_state <= S_TMUL;
                end
                S_TMUL: begin
                    if (!r_mw) begin
                        r_ma <= $signed({11'b0, t_ms});
                        r_mb <= $signed({14'b0, fs_sat});
                        r_mw <= 1'b1;
                    end else begin
                        r_mw    <= 1'b0;
                        r_state <= S_EDIV_LD;
                    end
                end
                S_EDIV_LD: begin
                    r_den   <= r_prod[DIV_D-1:0];
                    r_quo   <= E_NUM;
                    r_rem   <= '0;
                    r_dcnt  <= DCNT_W'(DIV_N);
                    r_state <= S_EDIV;
                end
                S_EDIV, S_PH1_DIV, S_PH2_DIV: begin
                    if (r_dcnt != '0) begin
                        r_rem  <= div_ge ? div_diff[DIV_D:0] : div_sh;
                        r_quo  <= {r_quo[DIV_N-2:0], div_ge};
                        r_dcnt <= r_dcnt - 1'b1;
                    end else if (r_state == S_EDIV) begin
                        r_state <= S_E2;
                    end else if (r_state == S_PH1_DIV) begin
                        r_state <= S_PH2_LD;
                    end else begin
                        r_ph2   <= r_ph2 + r_quo[PHASE_BITS-1:0];
                        r_osc   <= 1'b0;
                        r_state <= S_A_X2;
                    end
                end
                S_E2: begin
                    if (!r_mw) begin
                        r_e  <= r_quo[26:0];
                        r_ma <= $signed({9'b0, r_quo[26:0]});
                        r_mb <= $signed({5'b0, r_quo[26:0]});
                        r_mw <= 1'b1;
                    end else begin
                        r_mw    <= 1'b0;
                        r_state <= S_E3;
                    end
                end
                S_E3: begin
                    if (!r_mw) begin
                        r_e2 <= r_prod[53:32];
                        r_ma <= $signed({14'b0, r_prod[53:32]});
                        r_mb <= $signed({5'b0, r_e});
                        r_mw <= 1'b1;
                    end else begin
                        r_mw    <= 1'b0;
                        r_state <= S_E4;
                    end
                end
                S_E4: begin
                    if (!r_mw) begin
                        r_e3 <= r_prod[48:32];
                        r_ma <= $signed({19'b0, r_prod[48:32]});
                        r_mb <= $signed({5'b0, r_e});
                        r_mw <= 1'b1;
                    end else begin
                        r_mw    <= 1'b0;
                        r_state <= S_D6;
                    end
                end
                S_D6: begin
                    if (!r_mw) begin
                        r_e4 <= r_prod[43:32];
                        r_ma <= $signed({20'b0, r_e3[16:1]});
                        r_mb <= $signed({15'b0, RECIP3});
                        r_mw <= 1'b1;
                    end else begin
                        r_mw    <= 1'b0;
                        r_state <= S_D24;
                    end
                end
                S_D24: begin
                    if (!r_mw) begin
                        r_d6 <= r_prod[30:17];
                        r_ma <= $signed({27'b0, r_e4[11:3]});
                        r_mb <= $signed({15'b0, RECIP3});
                        r_mw <= 1'b1;
                    end else begin
                        r_mw    <= 1'b0;
                        r_state <= S_ENV;
                    end
                end
                S_ENV: begin
                    if (!r_mw) begin
                        r_ma <= $signed({3'b0, alpha[32:0]});
                        r_mb <= $signed({15'b0, r_env});
                        r_mw <= 1'b1;
                    end else begin
                        r_mw    <= 1'b0;
                        r_state <= S_PH1_LD;
                    end
                end
                S_PH1_LD: begin
                    if (r_run) begin
                        if (r_prod[48:32] < ENV_SNAP) begin
                            r_env <= '0;
                            r_run <= 1'b0;
                        end else begin
                            r_env <= r_prod[48:32];
                        end
                    end else begin
                        r_env <= '0;
                    end
                    r_quo   <= DIV_N'(freq_q16(r_c1)) << (PHASE_BITS - 16);
                    r_den   <= DIV_D'(fs_sat);
                    r_rem   <= '0;
                    r_dcnt  <= DCNT_W'(DIV_N);
                    r_state <= S_PH1_DIV;
                end
                S_PH2_LD: begin
                    r_ph1   <= r_ph1 + r_quo[PHASE_BITS-1:0];
                    r_quo   <= DIV_N'(freq_q16(r_c2)) << (PHASE_BITS - 16);
                    r_rem   <= '0;
                    r_dcnt  <= DCNT_W'(DIV_N);
                    r_state <= S_PH2_DIV;
                end
                S_A_X2: begin
                    if (!r_mw) begin
                        r_x  <= x_v;
                        r_ma <= $signed({5'b0, x_v});
                        r_mb <= $signed({1'b0, x_v});
                        r_mw <= 1'b1;
                    end else begin
                        r_mw    <= 1'b0;
                        r_state <= S_A_P7;
                    end
                end
                S_A_P7: begin
                    if (!r_mw) begin
                        r_x2 <= r_prod[60:30];
                        r_ma <= $signed({5'b0, r_prod[60:30]});
                        r_mb <= $signed(SIN_C7);
                        r_mw <= 1'b1;
                    end else begin
                        r_mw    <= 1'b0;
                        r_state <= S_A_P5;
                    end
                end
                S_A_P5: begin
                    if (!r_mw) begin
                        r_ma <= $signed({5'b0, r_x2});
                        r_mb <= $signed(SIN_C5 - r_prod[61:30]);
                        r_mw <= 1'b1;
                    end else begin
                        r_mw    <= 1'b0;
                        r_state <= S_A_P3;
                    end
                end
                S_A_P3: begin
                    if (!r_mw) begin
                        r_ma <= $signed({5'b0, r_x2});
                        r_mb <= $signed(SIN_C3 - r_prod[61:30]);
                        r_mw <= 1'b1;
                    end else begin
                        r_mw    <= 1'b0;
                        r_state <= S_A_P1;
                    end
                end
                S_A_P1: begin
                    if (!r_mw) begin
                        r_ma <= $signed({5'b0, r_x});
                        r_mb <= $signed(SIN_C1 - r_prod[61:30]);
                        r_mw <= 1'b1;
                    end else begin
                        r_mw    <= 1'b0;
                        r_state <= S_A_S;
                    end
                end
                S_A_S: begin
                    if (!r_osc) begin
                        r_wa    <= w_v;
                        r_osc   <= 1'b1;
                        r_state <= S_A_X2;
                    end else begin
                        r_wb    <= w_v;
                        r_state <= S_RING;
                    end
                end
                S_RING: begin
                    if (!r_mw) begin
                        r_ma <= 36'(r_wa);
                        r_mb <= 32'(r_wb);
                        r_mw <= 1'b1;
                    end else begin
                        r_mw    <= 1'b0;
                        r_state <= S_MIXA;
                    end
                end
                S_MIXA: begin
                    if (!r_mw) begin
                        r_ring <= ring_v;
                        r_ma   <= 36'(dry_v);
                        r_mb   <= $signed({15'b0, ENV_ONE - r_g});
                        r_mw   <= 1'b1;
                    end else begin
                        r_mw    <= 1'b0;
                        r_state <= S_MIXB;
                    end
                end
                S_MIXB: begin
                    if (!r_mw) begin
                        r_macc <= $signed(r_prod[49:0]);
                        r_ma   <= r_ring;
                        r_mb   <= $signed({15'b0, r_g});
                        r_mw   <= 1'b1;
                    end else begin
                        r_mw    <= 1'b0;
                        r_state <= S_OUT_MUL;
                    end
                end
                S_OUT_MUL: begin
                    if (!r_mw) begin
                        r_ma <= 36'(mix_v);
                        r_mb <= $signed({15'b0, r_env});
                        r_mw <= 1'b1;
                    end else begin
                        r_mw    <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_out    <= y_c[CV_BITS-1:0];
                        r_led    <= r_env;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        case (paddr[APB_AW-1:2])
            REG_YIP:    prdata = {20'b0, r_yip_knob};
            REG_YAP:    prdata = {20'b0, r_yap_knob};
            REG_GROWL:  prdata = {20'b0, r_growl_knob};
            REG_TAIL:   prdata = {20'b0, r_tail_knob};
            REG_SQUARE: prdata = {31'b0, r_sq_sw};
            REG_FS:     prdata = {14'b0, r_fs};
            default:    prdata = '0;
        endcase
    end

    assign pready         = 1'b1;
    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_ovalid;
    assign o_voice_sample = r_out;
    assign o_led_level    = r_led;

    a_env_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !r_run) |-> (r_env == '0))
        else $error("envelope nonzero while stopped");

    a_valid_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result raised outside final step");

    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dcnt != '0) |-> (r_state == S_EDIV || r_state == S_PH1_DIV
                            || r_state == S_PH2_DIV))
        else $error("divider running outside division step");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_voice_sample <= OUT_LIM && o_voice_sample >= -OUT_LIM))
        else $error("voice sample beyond clamp");

endmodule
